[src/scu_pkg.sv]
// Shared types, constants and saturation helpers for the charge unfolding block.
// Used by scu_mulq, scu_div and scintillation_charge_unfolding.
`default_nettype none

package scu_pkg;

    localparam int WINDOW_DEPTH_DEFAULT = 256;

    // fixed formats
    localparam int LEVEL_W = 48;
    localparam int CHARGE_W = 32;
    localparam int OUT_W = 31;
    localparam int COEF_W = 35;
    localparam int ENTRY_W = 2 * LEVEL_W + CHARGE_W;

    localparam logic signed [63:0] MAX48 = 64'sd140737488355327;
    localparam logic signed [63:0] MIN48 = -64'sd140737488355328;
    localparam logic signed [63:0] MULQ_LIM = 64'sd72057594037927935;
    localparam logic [COEF_W-1:0] ONE_Q32 = 35'h1_0000_0000;
    localparam logic [COEF_W-1:0] TWO_Q32 = 35'h2_0000_0000;
    localparam logic [COEF_W-1:0] C_LIM = 35'h4_0000_0000;

    // register addresses (word index)
    localparam logic [1:0] REG_FAST_FRACTION = 2'd0;
    localparam logic [1:0] REG_FAST_DECAY = 2'd1;
    localparam logic [1:0] REG_SLOW_DECAY = 2'd2;
    localparam logic [1:0] REG_WINDOW_TARGET = 2'd3;

    typedef logic signed [LEVEL_W-1:0] level_t;

    // clamp to the signed 48-bit level range
    function automatic level_t sat48(input logic signed [63:0] v);
        level_t r;
        if (v > MAX48)
            r = MAX48[LEVEL_W-1:0];
        else if (v < MIN48)
            r = MIN48[LEVEL_W-1:0];
        else
            r = v[LEVEL_W-1:0];
        return r;
    endfunction

    // clamp to the unsigned 31-bit result range
    function automatic logic [OUT_W-1:0] out31(input logic signed [63:0] v);
        logic [OUT_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > 64'sd2147483647)
            r = '1;
        else
            r = v[OUT_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[src/scu_mulq.sv]
// Multi-cycle fixed point multiply x*c/2^32, rounded half away from zero.
// Partial products of the low and the high 28 bits of x, then a rounding step; uses scu_pkg.
`default_nettype none

module scu_mulq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [63:0]            x,
    input  wire logic [scu_pkg::COEF_W-1:0]    c,
    output logic                               done,
    output logic signed [63:0]                 result
);

    logic [55:0] mag_reg;
    logic [scu_pkg::COEF_W-1:0] c_reg;
    logic neg_reg;
    logic [90:0] acc_reg;
    logic [1:0] step_reg;
    logic busy_reg;
    logic done_reg;
    logic signed [63:0] result_reg;

    logic signed [63:0] xc;
    logic [63:0] xmag;
    logic [58:0] rnd;

    // clamp operands at start
    always_comb
    begin
        if (x > scu_pkg::MULQ_LIM)
            xc = scu_pkg::MULQ_LIM;
        else if (x < -scu_pkg::MULQ_LIM)
            xc = -scu_pkg::MULQ_LIM;
        else
            xc = x;
        xmag = (xc < 0) ? 64'(-xc) : 64'(xc);
        rnd = 59'((acc_reg + 91'h8000_0000) >> 32);
    end

    // partial product sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= xmag[55:0];
            c_reg <= (c > scu_pkg::C_LIM) ? scu_pkg::C_LIM : c;
            neg_reg <= (xc < 0);
        end
        else if (busy_reg)
        begin
            unique case (step_reg)
                2'd0: acc_reg <= 91'(mag_reg[27:0] * c_reg[31:0])
                               + (91'(mag_reg * c_reg[34:32]) << 32);
                2'd1: acc_reg <= acc_reg + (91'(mag_reg[55:28] * c_reg[31:0]) << 28);
                default: result_reg <= neg_reg ? -$signed(64'(rnd)) : $signed(64'(rnd));
            endcase
        end
    end

    assign done = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[src/scu_div.sv]
// Bit-serial ratio num*2^32/den, limited to 2.0, 1.0 when den is zero.
// One quotient bit per cycle; uses scu_pkg.
`default_nettype none

module scu_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [32:0]                   num,
    input  wire logic [32:0]                   den,
    output logic                               done,
    output logic [scu_pkg::COEF_W-1:0]         ratio
);

    logic [33:0] rem_reg;
    logic [32:0] den_reg;
    logic [32:0] quo_reg;
    logic [5:0] cnt_reg;
    logic busy_reg;
    logic done_reg;
    logic [scu_pkg::COEF_W-1:0] ratio_reg;

    logic [33:0] shifted;

    assign shifted = {rem_reg[32:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (den == '0 || {1'b0, num} >= {den, 1'b0})
                    done_reg <= 1'b1;
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == 6'd32)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // restoring division, integer bit first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cnt_reg <= '0;
            den_reg <= den;
            if (den == '0)
                ratio_reg <= scu_pkg::ONE_Q32;
            else if ({1'b0, num} >= {den, 1'b0})
                ratio_reg <= scu_pkg::TWO_Q32;
            else if (num >= den)
            begin
                rem_reg <= 34'(num - den);
                quo_reg <= 33'd1;
            end
            else
            begin
                rem_reg <= 34'(num);
                quo_reg <= 33'd0;
            end
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd32)
                ratio_reg <= {2'b00, quo_reg};
            else if (shifted >= {1'b0, den_reg})
            begin
                rem_reg <= shifted - {1'b0, den_reg};
                quo_reg <= {quo_reg[31:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[31:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign ratio = ratio_reg;

endmodule

`default_nettype wire

[src/scintillation_charge_unfolding.sv]
// Top level of the scintillation charge unfolding block: sequencer, window memory.
// Depends on scu_pkg, scu_mulq and scu_div.
//
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    tdata: bin_charge; tuser: first_bin
//  m_*       out  m_tvalid / m_tready    tdata: unfolded_charge, fast_level, slow_level
//  apb       in   psel & penable         fast_fraction, fast_decay, slow_decay, target
//
// One request at a time; all products share one multiplier. A first bin
// only splits its charge. From the third bin of a record on, the window is
// summed and the oldest entries dropped, with a tail correction after a drop;
// a positive bin also uses the divider. The window memory has no clearing
// pass. A finished result waits in the output register and blocks the next
// request only once that one is done as well.
`default_nettype none

module scintillation_charge_unfolding #(
    parameter int WINDOW_DEPTH = scu_pkg::WINDOW_DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] bin_charge
    input  wire logic [0:0]  s_tuser,   // [0] first_bin
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // [30:0] unfolded_charge, [61:31] fast_level,
                                        // [92:62] slow_level
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int EW = scu_pkg::ENTRY_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);
    localparam logic [AW-1:0] LAST_A = AW'(WINDOW_DEPTH - 1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_FIRST_F = 5'd1;
    localparam logic [4:0] S_FIRST_S = 5'd2;
    localparam logic [4:0] S_PS_RD = 5'd3;
    localparam logic [4:0] S_PS_ACC = 5'd4;
    localparam logic [4:0] S_PL_CHK = 5'd5;
    localparam logic [4:0] S_PL_RD = 5'd6;
    localparam logic [4:0] S_PL_TEST = 5'd7;
    localparam logic [4:0] S_PL_END = 5'd8;
    localparam logic [4:0] S_PC_MUL = 5'd9;
    localparam logic [4:0] S_PC_WR = 5'd10;
    localparam logic [4:0] S_DEC_F = 5'd11;
    localparam logic [4:0] S_DEC_S = 5'd12;
    localparam logic [4:0] S_NC_MUL = 5'd13;
    localparam logic [4:0] S_NC_PN1 = 5'd14;
    localparam logic [4:0] S_NC_DIV = 5'd15;
    localparam logic [4:0] S_NC_G = 5'd16;
    localparam logic [4:0] S_NC_T = 5'd17;
    localparam logic [4:0] S_NC_F = 5'd18;
    localparam logic [4:0] S_NC_S = 5'd19;
    localparam logic [4:0] S_PUSH = 5'd20;
    localparam logic [4:0] S_OUT = 5'd21;

    // configuration registers
    logic [31:0] frac_reg, fdec_reg, sdec_reg;
    logic [30:0] target_reg;

    // control and datapath registers
    logic [4:0] state_reg, state_next;
    logic [1:0] seen_reg, seen_next;
    logic [AW-1:0] head_reg, head_next, ptr_reg, ptr_next;
    logic [CW-1:0] count_reg, count_next, j_reg, j_next;
    logic signed [31:0] d_reg, d_next;
    logic first_reg, first_next;
    scu_pkg::level_t fr_reg, fr_next, sr_reg, sr_next, lost_reg, lost_next;
    scu_pkg::level_t gamma_reg, gamma_next, nc_reg, nc_next;
    logic signed [63:0] tot_reg, tot_next, sf_reg, sf_next, ss_reg, ss_next;
    logic signed [63:0] sd_reg, sd_next;
    logic [32:0] pn_reg, pn_next, pn1_reg, pn1_next;
    logic [scu_pkg::COEF_W-1:0] ratio_reg, ratio_next;
    logic [30:0] r_unf_reg, r_unf_next, r_fast_reg, r_fast_next, r_slow_reg, r_slow_next;
    logic mul_pend_reg, mul_pend_next, div_pend_reg, div_pend_next;
    logic out_valid_reg;
    logic [92:0] out_data_reg;

    // window memory
    logic [EW-1:0] mem [WINDOW_DEPTH];
    logic [EW-1:0] mem_q_reg;
    logic mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;

    // shared units
    logic mul_go, mul_done, div_go, div_done, is_mul;
    logic signed [63:0] mul_x, mul_r;
    logic [scu_pkg::COEF_W-1:0] mul_c, one_minus_frac, div_ratio;

    logic signed [63:0] q_fast, q_slow, q_ch, tmp, target;
    logic [AW-1:0] ptr_inc, head_inc, head_push;
    logic [CW-1:0] count_push;
    logic [CW:0] slot_sum;
    logic accept, last_j;

    scu_mulq u_mulq (
        .clk(clk), .rst_n(rst_n), .start(mul_go), .x(mul_x), .c(mul_c),
        .done(mul_done), .result(mul_r)
    );

    scu_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_go),
        .num(33'(scu_pkg::ONE_Q32) - pn1_reg), .den(33'(scu_pkg::ONE_Q32) - pn_reg),
        .done(div_done), .ratio(div_ratio)
    );

    // configuration port
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg <= 32'd2147483648;
            fdec_reg <= 32'd3349030000;
            sdec_reg <= 32'd4282750000;
            target_reg <= 31'd65536;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                scu_pkg::REG_FAST_FRACTION: frac_reg <= pwdata;
                scu_pkg::REG_FAST_DECAY: fdec_reg <= pwdata;
                scu_pkg::REG_SLOW_DECAY: sdec_reg <= pwdata;
                default: target_reg <= pwdata[30:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            scu_pkg::REG_FAST_FRACTION: prdata = frac_reg;
            scu_pkg::REG_FAST_DECAY: prdata = fdec_reg;
            scu_pkg::REG_SLOW_DECAY: prdata = sdec_reg;
            default: prdata = {1'b0, target_reg};
        endcase
    end

    // memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_q_reg <= mem[ptr_reg];
    end

    assign q_fast = $signed(mem_q_reg[47:0]);
    assign q_slow = $signed(mem_q_reg[95:48]);
    assign q_ch = $signed(mem_q_reg[127:96]);

    assign one_minus_frac = scu_pkg::ONE_Q32 - 35'(frac_reg);
    assign ptr_inc = (ptr_reg == LAST_A) ? '0 : ptr_reg + 1'b1;
    assign head_inc = (head_reg == LAST_A) ? '0 : head_reg + 1'b1;
    assign last_j = ((j_reg + 1'b1) == count_reg);
    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    // multiplier operand select
    always_comb
    begin
        is_mul = 1'b1;
        mul_x = '0;
        mul_c = '0;
        unique case (state_reg)
            S_FIRST_F: begin mul_x = d_reg; mul_c = 35'(frac_reg); end
            S_FIRST_S: begin mul_x = d_reg; mul_c = one_minus_frac; end
            S_PC_MUL: begin mul_x = lost_reg; mul_c = 35'(sdec_reg); end
            S_DEC_F: begin mul_x = fr_reg; mul_c = 35'(fdec_reg); end
            S_DEC_S: begin mul_x = sr_reg; mul_c = 35'(sdec_reg); end
            S_NC_MUL, S_NC_PN1:
            begin
                mul_x = $signed(64'(pn_reg));
                mul_c = 35'(sdec_reg);
            end
            S_NC_G: begin mul_x = sf_reg + ss_reg; mul_c = ratio_reg; end
            S_NC_T: begin mul_x = gamma_reg; mul_c = 35'(pn1_reg); end
            S_NC_F: begin mul_x = nc_reg; mul_c = 35'(frac_reg); end
            S_NC_S: begin mul_x = nc_reg; mul_c = one_minus_frac; end
            default: is_mul = 1'b0;
        endcase
    end

    assign mul_go = is_mul && !mul_pend_reg;
    assign div_go = (state_reg == S_NC_DIV) && !div_pend_reg;

    // push slot after a possible full-window drop
    always_comb
    begin
        if (count_reg == DEPTH_C)
        begin
            head_push = head_inc;
            count_push = count_reg - 1'b1;
        end
        else
        begin
            head_push = head_reg;
            count_push = count_reg;
        end
        slot_sum = (CW + 1)'(head_push) + (CW + 1)'(count_push);
        if (slot_sum >= (CW + 1)'(WINDOW_DEPTH))
            slot_sum = slot_sum - (CW + 1)'(WINDOW_DEPTH);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        seen_next = seen_reg;
        head_next = head_reg;
        ptr_next = ptr_reg;
        count_next = count_reg;
        j_next = j_reg;
        d_next = d_reg;
        first_next = first_reg;
        fr_next = fr_reg;
        sr_next = sr_reg;
        lost_next = lost_reg;
        gamma_next = gamma_reg;
        nc_next = nc_reg;
        tot_next = tot_reg;
        sf_next = sf_reg;
        ss_next = ss_reg;
        sd_next = sd_reg;
        pn_next = pn_reg;
        pn1_next = pn1_reg;
        ratio_next = ratio_reg;
        r_unf_next = r_unf_reg;
        r_fast_next = r_fast_reg;
        r_slow_next = r_slow_reg;
        mul_pend_next = mul_go ? 1'b1 : (mul_done ? 1'b0 : mul_pend_reg);
        div_pend_next = div_go ? 1'b1 : (div_done ? 1'b0 : div_pend_reg);
        mem_we = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = mem_q_reg;
        tmp = '0;
        target = $signed({33'b0, target_reg}) - 64'(d_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    d_next = $signed(s_tdata);
                    first_next = s_tuser[0] || (seen_reg == 2'd0);
                    r_unf_next = '0;
                    r_fast_next = '0;
                    r_slow_next = '0;
                    lost_next = '0;
                    tot_next = '0;
                    j_next = '0;
                    ptr_next = head_reg;
                    if (s_tuser[0] || seen_reg == 2'd0)
                    begin
                        head_next = '0;
                        count_next = '0;
                        state_next = S_FIRST_F;
                    end
                    else if (seen_reg == 2'd2)
                        state_next = S_PS_RD;
                    else
                        state_next = S_DEC_F;
                end
            end
            S_FIRST_F:
                if (mul_done)
                begin
                    fr_next = scu_pkg::sat48(mul_r);
                    state_next = S_FIRST_S;
                end
            S_FIRST_S:
                if (mul_done)
                begin
                    sr_next = scu_pkg::sat48(mul_r);
                    r_unf_next = scu_pkg::out31(64'(d_reg));
                    r_fast_next = scu_pkg::out31(64'(fr_reg));
                    r_slow_next = scu_pkg::out31(64'(scu_pkg::sat48(mul_r)));
                    state_next = S_PUSH;
                end
            // window charge sum
            S_PS_RD: state_next = S_PS_ACC;
            S_PS_ACC:
            begin
                tot_next = tot_reg + q_ch;
                j_next = j_reg + 1'b1;
                ptr_next = ptr_inc;
                if (last_j)
                begin
                    ptr_next = head_reg;
                    state_next = S_PL_CHK;
                end
                else
                    state_next = S_PS_RD;
            end
            // drop oldest entries down to the target
            S_PL_CHK: state_next = (count_reg > CW'(1)) ? S_PL_RD : S_PL_END;
            S_PL_RD: state_next = S_PL_TEST;
            S_PL_TEST:
            begin
                tmp = tot_reg - q_ch;
                if (tmp >= target)
                begin
                    lost_next = q_slow[47:0];
                    tot_next = tmp;
                    head_next = head_inc;
                    ptr_next = head_inc;
                    count_next = count_reg - 1'b1;
                    state_next = S_PL_CHK;
                end
                else
                    state_next = S_PL_END;
            end
            S_PL_END:
            begin
                ptr_next = head_reg;
                j_next = '0;
                state_next = (lost_reg > 0) ? S_PC_MUL : S_DEC_F;
            end
            // tail correction
            S_PC_MUL:
                if (mul_done)
                begin
                    lost_next = mul_r[47:0];
                    state_next = S_PC_WR;
                end
            S_PC_WR:
            begin
                mem_we = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = {mem_q_reg[127:96],
                             scu_pkg::sat48(q_slow - 64'(lost_reg)),
                             scu_pkg::sat48(q_fast - 64'(lost_reg))};
                j_next = j_reg + 1'b1;
                ptr_next = ptr_inc;
                state_next = last_j ? S_DEC_F : S_PC_MUL;
            end
            // decay of the running levels
            S_DEC_F:
                if (mul_done)
                begin
                    fr_next = scu_pkg::sat48(mul_r);
                    state_next = S_DEC_S;
                end
            S_DEC_S:
                if (mul_done)
                begin
                    sr_next = scu_pkg::sat48(mul_r);
                    sf_next = '0;
                    ss_next = '0;
                    sd_next = '0;
                    pn_next = 33'(scu_pkg::ONE_Q32);
                    ptr_next = head_reg;
                    j_next = '0;
                    if (d_reg <= 0)
                        state_next = S_PUSH;
                    else
                        state_next = (count_reg == '0) ? S_NC_PN1 : S_NC_MUL;
                end
            // window sums and decay power
            S_NC_MUL:
                if (mul_done)
                begin
                    pn_next = mul_r[32:0];
                    sf_next = sf_reg + q_fast;
                    ss_next = ss_reg + q_slow;
                    sd_next = sd_reg + q_ch;
                    j_next = j_reg + 1'b1;
                    ptr_next = ptr_inc;
                    if (last_j)
                        state_next = S_NC_PN1;
                end
            S_NC_PN1:
                if (mul_done)
                begin
                    pn1_next = mul_r[32:0];
                    state_next = S_NC_DIV;
                end
            S_NC_DIV:
                if (div_done)
                begin
                    ratio_next = div_ratio;
                    state_next = S_NC_G;
                end
            S_NC_G:
                if (mul_done)
                begin
                    tmp = sd_reg - mul_r;
                    if (tmp < 0)
                        gamma_next = '0;
                    else
                        gamma_next = scu_pkg::sat48(tmp);
                    state_next = S_NC_T;
                end
            S_NC_T:
                if (mul_done)
                begin
                    tmp = 64'(d_reg) - (64'(fr_reg) + 64'(sr_reg)) - mul_r;
                    if (tmp < 0)
                        nc_next = '0;
                    else
                        nc_next = scu_pkg::sat48(tmp);
                    state_next = S_NC_F;
                end
            S_NC_F:
                if (mul_done)
                begin
                    fr_next = scu_pkg::sat48(64'(fr_reg) + mul_r);
                    state_next = S_NC_S;
                end
            S_NC_S:
                if (mul_done)
                begin
                    sr_next = scu_pkg::sat48(64'(sr_reg) + mul_r);
                    r_unf_next = scu_pkg::out31(64'(nc_reg));
                    r_fast_next = scu_pkg::out31(64'(fr_reg));
                    r_slow_next = scu_pkg::out31(64'(scu_pkg::sat48(64'(sr_reg) + mul_r)));
                    state_next = S_PUSH;
                end
            // push the new entry
            S_PUSH:
            begin
                mem_we = 1'b1;
                mem_waddr = slot_sum[AW-1:0];
                mem_wdata = {d_reg, sr_reg, fr_reg};
                head_next = head_push;
                count_next = count_push + 1'b1;
                seen_next = first_reg ? 2'd1 : 2'd2;
                state_next = S_OUT;
            end
            S_OUT:
                if (!out_valid_reg)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seen_reg <= '0;
            head_reg <= '0;
            count_reg <= '0;
            mul_pend_reg <= 1'b0;
            div_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg <= seen_next;
            head_reg <= head_next;
            count_reg <= count_next;
            mul_pend_reg <= mul_pend_next;
            div_pend_reg <= div_pend_next;
            if (state_reg == S_OUT && !out_valid_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        j_reg <= j_next;
        d_reg <= d_next;
        first_reg <= first_next;
        fr_reg <= fr_next;
        sr_reg <= sr_next;
        lost_reg <= lost_next;
        gamma_reg <= gamma_next;
        nc_reg <= nc_next;
        tot_reg <= tot_next;
        sf_reg <= sf_next;
        ss_reg <= ss_next;
        sd_reg <= sd_next;
        pn_reg <= pn_next;
        pn1_reg <= pn1_next;
        ratio_reg <= ratio_next;
        r_unf_reg <= r_unf_next;
        r_fast_reg <= r_fast_next;
        r_slow_reg <= r_slow_next;
        if (state_reg == S_OUT && !out_valid_reg)
            out_data_reg <= {r_slow_reg, r_fast_reg, r_unf_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {3'b000, out_data_reg};

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("window count above depth");

    a_seen_code: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg != 2'd3)
        else $error("bad record phase");

    a_window_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (seen_reg != 2'd0 && state_reg == S_IDLE) |-> count_reg != '0)
        else $error("empty window inside a record");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("request taken while busy");

endmodule

`default_nettype wire
